[sv/gda_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian date adder.
package gda_pkg;

    localparam logic [1:0] CMD_ADD_DAYS     = 2'd0;
    localparam logic [1:0] CMD_ADD_MONTHS   = 2'd1;
    localparam logic [1:0] CMD_YEARS_STEP   = 2'd2;
    localparam logic [1:0] CMD_YEARS_AT_ONCE = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_INVALID  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [13:0] CYCLE_YEARS   = 14'd400;
    localparam logic [13:0] CYCLE_LAST    = 14'd399;
    localparam logic [8:0]  CENTURY_1     = 9'd100;
    localparam logic [8:0]  CENTURY_2     = 9'd200;
    localparam logic [8:0]  CENTURY_3     = 9'd300;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [4:0]  FEB_LEAP_LEN  = 5'd29;
    localparam logic [4:0]  FEB_SHORT_LEN = 5'd28;
    localparam logic [15:0] MONTHS_PER_YEAR = 16'd12;

    // Highest shift of the year-cycle length that fits in a 14-bit year.
    localparam logic [2:0]  MOD_TOP_SHIFT = 3'd5;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic load;
        logic mod_step;
        logic set_invalid;
        logic years_load;
        logic year_fix;
        logic walk_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic       mod_last;
        logic       date_ok;
        logic       year_ovf;
        logic       walk_last;
        logic [1:0] command;
    } t_dp_stat;

    // Leap test from the two low year bits and the year modulo 400.
    function automatic logic is_leap(input logic [1:0] y_lo, input logic [8:0] y400);
        return (y_lo == 2'd0) && (y400 != CENTURY_1) && (y400 != CENTURY_2)
               && (y400 != CENTURY_3);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        if (m == MONTH_FEB) begin
            len = leap ? FEB_LEAP_LEN : FEB_SHORT_LEN;
        end else if ((m >= MONTH_JAN) && (m <= MONTH_DEC)) begin
            len = MONTH_LEN[m - MONTH_JAN];
        end
        return len;
    endfunction

    function automatic logic [13:0] mod_bound(input logic [2:0] k);
        return CYCLE_YEARS << k;
    endfunction

endpackage

[sv/gregorian_date_adder.sv]
// Gregorian date adder: adds days, months or years to a date, one item at a time.
//
// Input: drive i_command, i_amount, i_day_in, i_month_in, i_year_in and raise
// start; the item is taken at the clock edge where start is high and busy is
// low. busy stays high until the item is finished.
// Output: o_valid pulses for one cycle with o_day_out, o_month_out, o_year_out
// and o_status; the receiver takes it then and cannot hold it off. The result
// registers keep their value until the next result.
// Steps: the year residue unit reduces the input year, the date is checked, then
// - add days: one step per month walked,
// - add months: one step per whole year while at least 12 months remain and the
//   day is 28 or less, else one step per month,
// - add years: a residue pass on the new year and one fix-up step,
// and last the output and the return to idle; an invalid date or a years overflow
// goes from the check to the output. The month walker is the limit on throughput.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears
// o_valid; an item in flight is dropped.
module gregorian_date_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_amount,
    input  logic [4:0]  i_day_in,
    input  logic [3:0]  i_month_in,
    input  logic [13:0] i_year_in,
    output logic        o_valid,
    output logic [4:0]  o_day_out,
    output logic [3:0]  o_month_out,
    output logic [13:0] o_year_out,
    output logic [1:0]  o_status
);

    gda_pkg::t_dp_cmd  dp_cmd;
    gda_pkg::t_dp_stat dp_stat;

    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    gda_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_command   (i_command),
        .i_amount    (i_amount),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .o_stat      (dp_stat),
        .o_valid     (o_valid),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_status    (o_status)
    );

endmodule

[sv/gda_datapath.sv]
// Datapath of the date adder: date registers, year-cycle residue unit and step logic.
module gda_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gda_pkg::t_dp_cmd   i_cmd,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_amount,
    input  logic [4:0]         i_day_in,
    input  logic [3:0]         i_month_in,
    input  logic [13:0]        i_year_in,
    output gda_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    output logic [4:0]         o_day_out,
    output logic [3:0]         o_month_out,
    output logic [13:0]        o_year_out,
    output logic [1:0]         o_status
);

    logic [1:0]  r_cmd, n_cmd;
    logic [4:0]  r_d0, n_d0;
    logic [3:0]  r_m0, n_m0;
    logic [13:0] r_y0, n_y0;
    logic [4:0]  r_d, n_d;
    logic [3:0]  r_m, n_m;
    logic [13:0] r_y, n_y;
    logic [15:0] r_rem, n_rem;
    logic [13:0] r_mrem, n_mrem;
    logic [2:0]  r_k, n_k;
    logic [1:0]  r_stat, n_stat;
    logic        r_valid, n_valid;
    logic [4:0]  r_od, n_od;
    logic [3:0]  r_om, n_om;
    logic [13:0] r_oy, n_oy;
    logic [1:0]  r_os, n_os;

    logic        leap_cur, leap_nxt, wrap, y_last, days_fit, jump, walk_ovf, year_ovf;
    logic [4:0]  dim_cur, left, len_nxt;
    logic [3:0]  m_nxt;
    logic [13:0] y_nxt, y400_inc, y400_nxt, bound;
    logic [16:0] year_sum;
    logic        is_days;

    always_comb begin
        is_days  = (r_cmd == gda_pkg::CMD_ADD_DAYS);
        leap_cur = gda_pkg::is_leap(r_y[1:0], r_mrem[8:0]);
        dim_cur  = gda_pkg::days_in(r_m, leap_cur);
        left     = dim_cur - r_d;
        y_last   = (r_y == gda_pkg::YEAR_MAX);
        y400_inc = (r_mrem == gda_pkg::CYCLE_LAST) ? 14'd0 : r_mrem + 14'd1;
        wrap     = (r_m == gda_pkg::MONTH_DEC);
        m_nxt    = wrap ? gda_pkg::MONTH_JAN : r_m + 4'd1;
        y_nxt    = wrap ? r_y + 14'd1 : r_y;
        y400_nxt = wrap ? y400_inc : r_mrem;
        leap_nxt = gda_pkg::is_leap(y_nxt[1:0], y400_nxt[8:0]);
        len_nxt  = gda_pkg::days_in(m_nxt, leap_nxt);
        days_fit = (r_rem <= {11'd0, left});
        jump     = (r_rem >= gda_pkg::MONTHS_PER_YEAR) && (r_d <= gda_pkg::FEB_SHORT_LEN);
        if (is_days) begin
            walk_ovf = !days_fit && wrap && y_last;
        end else begin
            walk_ovf = (r_rem != 16'd0) && y_last && (jump || wrap);
        end
        year_sum = {3'd0, r_y0} + {1'b0, r_rem};
        year_ovf = (year_sum > {3'd0, gda_pkg::YEAR_MAX});
        bound    = gda_pkg::mod_bound(r_k);

        o_stat.mod_last  = (r_k == 3'd0);
        o_stat.date_ok   = (r_m >= gda_pkg::MONTH_JAN) && (r_m <= gda_pkg::MONTH_DEC)
                           && (r_y != 14'd0) && (r_y <= gda_pkg::YEAR_MAX)
                           && (r_d != 5'd0) && (r_d <= dim_cur);
        o_stat.year_ovf  = year_ovf;
        o_stat.walk_last = walk_ovf || (is_days ? days_fit : (r_rem == 16'd0));
        o_stat.command   = r_cmd;
    end

    always_comb begin
        n_cmd   = r_cmd;
        n_d0    = r_d0;
        n_m0    = r_m0;
        n_y0    = r_y0;
        n_d     = r_d;
        n_m     = r_m;
        n_y     = r_y;
        n_rem   = r_rem;
        n_mrem  = r_mrem;
        n_k     = r_k;
        n_stat  = r_stat;
        n_valid = 1'b0;
        n_od    = r_od;
        n_om    = r_om;
        n_oy    = r_oy;
        n_os    = r_os;

        if (i_cmd.load) begin
            n_cmd  = i_command;
            n_d0   = i_day_in;
            n_m0   = i_month_in;
            n_y0   = i_year_in;
            n_d    = i_day_in;
            n_m    = i_month_in;
            n_y    = i_year_in;
            n_rem  = i_amount;
            n_mrem = i_year_in;
            n_k    = gda_pkg::MOD_TOP_SHIFT;
            n_stat = gda_pkg::STATUS_OK;
        end

        // restoring residue step: one shifted copy of 400 per cycle
        if (i_cmd.mod_step) begin
            if (r_mrem >= bound) begin
                n_mrem = r_mrem - bound;
            end
            n_k = r_k - 3'd1;
        end

        if (i_cmd.set_invalid) begin
            n_stat = gda_pkg::STATUS_INVALID;
        end

        if (i_cmd.years_load) begin
            if (year_ovf) begin
                n_stat = gda_pkg::STATUS_OVERFLOW;
            end else begin
                n_y    = year_sum[13:0];
                n_mrem = year_sum[13:0];
                n_k    = gda_pkg::MOD_TOP_SHIFT;
            end
        end

        if (i_cmd.year_fix) begin
            if ((r_m == gda_pkg::MONTH_FEB) && (r_d == gda_pkg::FEB_LEAP_LEN)) begin
                if (r_cmd == gda_pkg::CMD_YEARS_STEP) begin
                    if (r_rem != 16'd0) begin
                        n_d = gda_pkg::FEB_SHORT_LEN;
                    end
                end else if (!leap_cur) begin
                    n_d = gda_pkg::FEB_SHORT_LEN;
                end
            end
        end

        if (i_cmd.walk_step) begin
            if (walk_ovf) begin
                n_stat = gda_pkg::STATUS_OVERFLOW;
            end else if (is_days) begin
                if (days_fit) begin
                    n_d   = r_d + r_rem[4:0];
                    n_rem = 16'd0;
                end else begin
                    // roll to the first of the next month
                    n_rem  = r_rem - {11'd0, left} - 16'd1;
                    n_d    = 5'd1;
                    n_m    = m_nxt;
                    n_y    = y_nxt;
                    n_mrem = y400_nxt;
                end
            end else if (r_rem != 16'd0) begin
                if (jump) begin
                    // a whole year cannot clamp a day of 28 or less
                    n_rem  = r_rem - gda_pkg::MONTHS_PER_YEAR;
                    n_y    = r_y + 14'd1;
                    n_mrem = y400_inc;
                end else begin
                    n_rem  = r_rem - 16'd1;
                    n_m    = m_nxt;
                    n_y    = y_nxt;
                    n_mrem = y400_nxt;
                    if (r_d > len_nxt) begin
                        n_d = len_nxt;
                    end
                end
            end
        end

        if (i_cmd.emit) begin
            n_valid = 1'b1;
            n_os    = r_stat;
            if (r_stat != gda_pkg::STATUS_OK) begin
                n_od = r_d0;
                n_om = r_m0;
                n_oy = r_y0;
            end else begin
                n_od = r_d;
                n_om = r_m;
                n_oy = r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stat  <= gda_pkg::STATUS_OK;
        end else begin
            r_valid <= n_valid;
            r_stat  <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_d0   <= n_d0;
        r_m0   <= n_m0;
        r_y0   <= n_y0;
        r_d    <= n_d;
        r_m    <= n_m;
        r_y    <= n_y;
        r_rem  <= n_rem;
        r_mrem <= n_mrem;
        r_k    <= n_k;
        r_od   <= n_od;
        r_om   <= n_om;
        r_oy   <= n_oy;
        r_os   <= n_os;
    end

    assign o_valid     = r_valid;
    assign o_day_out   = r_od;
    assign o_month_out = r_om;
    assign o_year_out  = r_oy;
    assign o_status    = r_os;

endmodule

[sv/gda_ctrl.sv]
// Sequencer of the date adder: accepts an item and steps the datapath through it.
module gda_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  gda_pkg::t_dp_stat  i_stat,
    output gda_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MOD1  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_MOD2  = 7'b0001000,
        S_YFIX  = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD1;
                end
            end
            S_MOD1: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.date_ok) begin
                    o_cmd.set_invalid = 1'b1;
                    n_state           = S_DONE;
                end else if ((i_stat.command == gda_pkg::CMD_ADD_DAYS)
                             || (i_stat.command == gda_pkg::CMD_ADD_MONTHS)) begin
                    n_state = S_WALK;
                end else begin
                    o_cmd.years_load = 1'b1;
                    n_state          = i_stat.year_ovf ? S_DONE : S_MOD2;
                end
            end
            S_MOD2: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_last) begin
                    n_state = S_YFIX;
                end
            end
            S_YFIX: begin
                o_cmd.year_fix = 1'b1;
                n_state        = S_DONE;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

[sv/gda_checker.sv]
// Port-level checks for the date adder, bound to the top level.
module gda_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [4:0]  o_day_out,
    input logic [3:0]  o_month_out,
    input logic [13:0] o_year_out,
    input logic [1:0]  o_status
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without finished work");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == gda_pkg::STATUS_OK) || (o_status == gda_pkg::STATUS_INVALID)
                     || (o_status == gda_pkg::STATUS_OVERFLOW)))
        else $error("undefined status code");

    a_ok_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == gda_pkg::STATUS_OK)) |->
        ((o_day_out != 5'd0) && (o_month_out != 4'd0) && (o_month_out <= gda_pkg::MONTH_DEC)
         && (o_year_out != 14'd0) && (o_year_out <= gda_pkg::YEAR_MAX)))
        else $error("ok result outside the calendar range");

endmodule

bind gregorian_date_adder gda_checker u_gda_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_day_out   (o_day_out),
    .o_month_out (o_month_out),
    .o_year_out  (o_year_out),
    .o_status    (o_status)
);

[bench/tb_gregorian_date_adder.sv]
// Self-checking testbench for the Gregorian date adder, with its own date predictor.
module tb_gregorian_date_adder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] amount;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date_request;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [1:0]  status;
    } t_date_result;

    localparam int RANDOM_REQUESTS = 550;
    localparam int DRAIN_CYCLES    = 16;
    // Worst case: items of 65535 months plus sender gaps, several times over.
    localparam int CYCLE_LIMIT     = 12_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_command = gda_pkg::CMD_ADD_DAYS;
    logic [15:0] i_amount = 16'd0;
    logic [4:0]  i_day_in = 5'd1;
    logic [3:0]  i_month_in = 4'd1;
    logic [13:0] i_year_in = 14'd1;
    logic        o_valid;
    logic [4:0]  o_day_out;
    logic [3:0]  o_month_out;
    logic [13:0] o_year_out;
    logic [1:0]  o_status;

    t_date_request pending_requests[$];
    t_date_result  expected_dates[$];
    t_date_request current_request;
    int            accepted_count = 0;
    int            result_count = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            burst_left = 1;
    int            gap_left = 0;

    gregorian_date_adder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_amount    (i_amount),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .o_valid     (o_valid),
        .o_day_out   (o_day_out),
        .o_month_out (o_month_out),
        .o_year_out  (o_year_out),
        .o_status    (o_status)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        int unsigned len;
        case (m)
            2: begin
                len = leap_year(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                len = 30;
            end
            1, 3, 5, 7, 8, 10, 12: begin
                len = 31;
            end
            default: begin
                len = 0;
            end
        endcase
        return len;
    endfunction

    function automatic t_date_result advance_date(t_date_request rq);
        int unsigned  d, m, y, rem, left, i;
        logic [1:0]   st;
        t_date_result res;
        d  = rq.day;
        m  = rq.month;
        y  = rq.year;
        st = gda_pkg::STATUS_OK;
        if (m < 1 || m > 12 || y < 1 || y > gda_pkg::YEAR_MAX
            || d < 1 || d > month_length(m, y)) begin
            st = gda_pkg::STATUS_INVALID;
        end else begin
            case (rq.command)
                gda_pkg::CMD_ADD_DAYS: begin
                    rem = rq.amount;
                    while (rem > 0 && st == gda_pkg::STATUS_OK) begin
                        left = month_length(m, y) - d;
                        if (rem <= left) begin
                            d += rem;
                            rem = 0;
                        end else begin
                            // roll into the first of the next month
                            rem -= left + 1;
                            d = 1;
                            if (m == 12) begin
                                m = 1;
                                y++;
                                if (y > gda_pkg::YEAR_MAX) st = gda_pkg::STATUS_OVERFLOW;
                            end else begin
                                m++;
                            end
                        end
                    end
                end
                gda_pkg::CMD_ADD_MONTHS: begin
                    i = 0;
                    while (i < rq.amount && st == gda_pkg::STATUS_OK) begin
                        if (m == 12) begin
                            m = 1;
                            y++;
                        end else begin
                            m++;
                        end
                        // a clamped day stays clamped in later months
                        if (y > gda_pkg::YEAR_MAX) st = gda_pkg::STATUS_OVERFLOW;
                        else if (d > month_length(m, y)) d = month_length(m, y);
                        i++;
                    end
                end
                default: begin
                    y = rq.year + rq.amount;
                    if (y > gda_pkg::YEAR_MAX) begin
                        st = gda_pkg::STATUS_OVERFLOW;
                    end else if (m == 2 && d == 29) begin
                        if (rq.command == gda_pkg::CMD_YEARS_STEP) begin
                            if (rq.amount >= 1) d = 28;
                        end else if (!leap_year(y)) begin
                            d = 28;
                        end
                    end
                end
            endcase
        end
        if (st != gda_pkg::STATUS_OK) begin
            d = rq.day;
            m = rq.month;
            y = rq.year;
        end
        res.day    = 5'(d);
        res.month  = 4'(m);
        res.year   = 14'(y);
        res.status = st;
        return res;
    endfunction

    function automatic t_date_request random_request();
        t_date_request rq;
        int unsigned   pick, len;
        rq.command = 2'($urandom_range(3, 0));
        pick = $urandom_range(99, 0);
        // keep most amounts short; the month walker is slow on big ones
        if (pick < 5)       rq.amount = 16'($urandom);
        else if (pick < 30) rq.amount = 16'($urandom_range(2000, 0));
        else                rq.amount = 16'($urandom_range(60, 0));
        pick = $urandom_range(99, 0);
        if (pick < 8) begin
            rq.day   = 5'($urandom);
            rq.month = 4'($urandom);
            rq.year  = 14'($urandom);
        end else begin
            if (pick < 20)      rq.year = 14'($urandom_range(9999, 9990));
            else if (pick < 35) rq.year = 14'($urandom_range(99, 1) * 100);
            else                rq.year = 14'($urandom_range(9999, 1));
            rq.month = 4'($urandom_range(12, 1));
            len = month_length(rq.month, rq.year);
            // favor the month end, where clamping and rollover live
            if ($urandom_range(1, 0) == 1) rq.day = 5'($urandom_range(len, len - 3));
            else                           rq.day = 5'($urandom_range(len, 1));
        end
        return rq;
    endfunction

    task automatic add_request(input logic [1:0] cmd, input logic [15:0] amt,
                               input logic [4:0] d, input logic [3:0] m,
                               input logic [13:0] y);
        t_date_request rq;
        rq.command = cmd;
        rq.amount  = amt;
        rq.day     = d;
        rq.month   = m;
        rq.year    = y;
        pending_requests.push_back(rq);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns, result %0d: %s", $time, result_count, msg);
        mismatch_count++;
    endtask

    // Driver: bursts of items separated by random gaps.
    always @(posedge i_clk) begin
        logic drive_start;
        drive_start = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_dates.push_back(advance_date(current_request));
                accepted_count++;
            end
            if (start && busy) begin
                drive_start = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                current_request = pending_requests.pop_front();
                i_command  <= current_request.command;
                i_amount   <= current_request.amount;
                i_day_in   <= current_request.day;
                i_month_in <= current_request.month;
                i_year_in  <= current_request.year;
                drive_start = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20)
                                                             : $urandom_range(8, 1);
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
                end
            end
            start <= drive_start;
        end
    end

    // Monitor: results cannot be held off, so check every strobe.
    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n && o_valid) begin
            if (expected_dates.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d-%0d-%0d status %0d",
                                          o_year_out, o_month_out, o_day_out, o_status));
            end else begin
                want = expected_dates.pop_front();
                if (o_day_out !== want.day)
                    report_mismatch($sformatf("day %0d, want %0d", o_day_out, want.day));
                if (o_month_out !== want.month)
                    report_mismatch($sformatf("month %0d, want %0d", o_month_out, want.month));
                if (o_year_out !== want.year)
                    report_mismatch($sformatf("year %0d, want %0d", o_year_out, want.year));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int total;
        // days: zero, year end, overflow, longest walk, leap and century Februaries
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd0, 5'd15, 4'd6, 14'd2024);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd31, 4'd12, 14'd9998);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd31, 4'd12, 14'd9999);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'hFFFF, 5'd1, 4'd1, 14'd1);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd28, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd28, 4'd2, 14'd1900);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd365, 5'd1, 4'd3, 14'd2023);
        // months: clamp, clamp carried forward, longest walk, overflow, zero
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd1, 5'd31, 4'd1, 14'd2023);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd2, 5'd31, 4'd1, 14'd2024);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'hFFFF, 5'd1, 4'd1, 14'd1);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd1, 5'd1, 4'd12, 14'd9999);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd0, 5'd31, 4'd5, 14'd2020);
        // years: Feb 29 handling of both commands, overflow, top year
        add_request(gda_pkg::CMD_YEARS_STEP, 16'd0, 5'd29, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_STEP, 16'd4, 5'd29, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_AT_ONCE, 16'd4, 5'd29, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_AT_ONCE, 16'd100, 5'd29, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_AT_ONCE, 16'd400, 5'd29, 4'd2, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_STEP, 16'hFFFF, 5'd31, 4'd12, 14'd1);
        add_request(gda_pkg::CMD_YEARS_AT_ONCE, 16'd7999, 5'd1, 4'd1, 14'd2000);
        // invalid dates
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd5, 5'd0, 4'd3, 14'd2010);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd1, 5'd31, 4'd4, 14'd2021);
        add_request(gda_pkg::CMD_YEARS_STEP, 16'd1, 5'd29, 4'd2, 14'd1900);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd1, 4'd0, 14'd2000);
        add_request(gda_pkg::CMD_ADD_MONTHS, 16'd1, 5'd1, 4'd13, 14'd2000);
        add_request(gda_pkg::CMD_YEARS_AT_ONCE, 16'hFFFF, 5'd31, 4'd15, 14'h3FFF);
        add_request(gda_pkg::CMD_ADD_DAYS, 16'd1, 5'd1, 4'd1, 14'd0);
        repeat (RANDOM_REQUESTS) pending_requests.push_back(random_request());
        total = pending_requests.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total) @(posedge i_clk);
        while (expected_dates.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
